### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use checks on the rising edge of clk
// and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/psc_pkg.sv
package psc_pkg;

    // Stored depth width. Kept depths are positive and never exceed 16 bits.
    localparam int DEPTH_W = 16;

    typedef struct packed {
        logic busy;
        logic done;
    } psc_div_status_t;

endpackage

### hw/rtl/psc_ram.sv
module psc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/psc_div.sv
module psc_div #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DVD_W-1:0]          dividend,
    input  logic [DVS_W-1:0]          divisor,
    output logic [DVD_W-1:0]          quotient,
    output psc_pkg::psc_div_status_t  status
);

    import psc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // One restoring step per cycle, quotient bits shift in from the right.
                if (fits)
                begin
                    rem_reg <= DVS_W'(trial - {1'b0, divisor});
                end
                else
                begin
                    rem_reg <= trial[DVS_W-1:0];
                end
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### hw/rtl/point_set_centroid_median.sv
// Centroid and median depth of a set of 3D surface samples.
// Input channel (in_valid/in_ready): one sample per beat, x_mm, y_mm, z_mm, sample_ok
// and last. While a set loads, one beat is taken every cycle. The first MAX_POINTS
// beats of a set are looked at; a sample is kept when sample_ok is 1 and z_mm > 0.
// A beat with last = 1 ends the set; in_ready then drops until the result is written
// to the output register.
// After the last beat the block runs two bisection searches over the 16 depth bits,
// each bit a full pass over the depth RAM (one read per cycle), then three passes of
// the shared bit-serial divider for the x, y and z means. A failed set skips both.
// Output channel (out_valid/out_ready): one result beat per set, held in a register.
// Loading of the next set goes on while that beat waits; a new set's last beat waits
// in the final step until the previous result has been taken.
// Configuration (cfg_valid/cfg_ready/cfg_data): writes min_points, always ready.
// Reset clears the sums and counts, empties the output and sets min_points to 16.
module point_set_centroid_median #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_mm,
    input  logic signed [15:0] y_mm,
    input  logic signed [16:0] z_mm,
    input  logic               sample_ok,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               success,
    output logic signed [15:0] centroid_x_mm,
    output logic signed [15:0] centroid_y_mm,
    output logic [15:0]        centroid_z_mm,
    output logic [16:0]        median_depth_half_mm,
    output logic [10:0]        kept_points
);

    import psc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = 18 + CNT_W;
    localparam int CMP_W  = (CNT_W > 11) ? CNT_W : 11;
    localparam int BIT_W  = $clog2(DEPTH_W);

    localparam logic [1:0] DIV_X = 2'd0;
    localparam logic [1:0] DIV_Y = 2'd1;
    localparam logic [1:0] DIV_Z = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_SEL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [10:0]              min_points_reg;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [SUM_W-1:0]  sum_z_reg;
    logic [CNT_W-1:0]         kept_reg;
    logic [CNT_W-1:0]         seen_reg;
    logic                     ok_reg;
    logic                     pass_reg;
    logic [BIT_W-1:0]         bit_reg;
    logic [DEPTH_W-1:0]       cand_reg;
    logic [DEPTH_W-1:0]       med_a_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         cnt_lt_reg;
    logic                     dv_reg;
    logic [1:0]               div_sel_reg;
    logic [15:0]              cx_reg;
    logic [15:0]              cy_reg;
    logic [15:0]              cz_reg;
    logic [16:0]              med_reg;
    logic                     out_valid_reg;
    logic                     out_success_reg;
    logic [15:0]              out_cx_reg;
    logic [15:0]              out_cy_reg;
    logic [15:0]              out_cz_reg;
    logic [16:0]              out_med_reg;
    logic [10:0]              out_kept_reg;

    logic                     in_fire;
    logic                     keep;
    logic [CMP_W-1:0]         need;
    logic                     set_ok;
    logic [CNT_W-1:0]         mid;
    logic [CNT_W-1:0]         k_target;
    logic [DEPTH_W-1:0]       trial_val;
    logic                     issuing;
    logic [DEPTH_W-1:0]       rd_data;
    logic signed [SUM_W-1:0]  div_sum;
    logic [SUM_W-1:0]         div_mag;
    logic                     div_start;
    logic [SUM_W-1:0]         div_q;
    psc_div_status_t          div_st;
    logic [15:0]              q_signed;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign keep      = (seen_reg < CNT_W'(MAX_POINTS)) && sample_ok && !z_mm[16]
                       && (z_mm != 17'sd0);

    assign need   = (min_points_reg == 11'd0) ? CMP_W'(1) : CMP_W'(min_points_reg);
    assign set_ok = (kept_reg != '0) && (CMP_W'(kept_reg) >= need);

    assign mid       = kept_reg >> 1;
    assign k_target  = (pass_reg || kept_reg[0]) ? mid : mid - 1'b1;
    assign trial_val = cand_reg | (DEPTH_W'(1) << bit_reg);
    assign issuing   = (state_reg == S_SEL) && (idx_reg < kept_reg);

    psc_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_POINTS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (in_fire && keep),
        .waddr (kept_reg[ADDR_W-1:0]),
        .wdata (z_mm[DEPTH_W-1:0]),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        case (div_sel_reg)
            DIV_X:   div_sum = sum_x_reg;
            DIV_Y:   div_sum = sum_y_reg;
            default: div_sum = sum_z_reg;
        endcase
    end

    assign div_mag   = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
    assign div_start = (state_reg == S_DIV_GO);
    assign q_signed  = div_sum[SUM_W-1] ? 16'(-div_q[15:0]) : div_q[15:0];

    psc_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (kept_reg),
        .quotient (div_q),
        .status   (div_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            min_points_reg  <= 11'd16;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_z_reg       <= '0;
            kept_reg        <= '0;
            seen_reg        <= '0;
            ok_reg          <= 1'b0;
            pass_reg        <= 1'b0;
            bit_reg         <= '0;
            cand_reg        <= '0;
            med_a_reg       <= '0;
            idx_reg         <= '0;
            cnt_lt_reg      <= '0;
            dv_reg          <= 1'b0;
            div_sel_reg     <= DIV_X;
            cx_reg          <= '0;
            cy_reg          <= '0;
            cz_reg          <= '0;
            med_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_success_reg <= 1'b0;
            out_cx_reg      <= '0;
            out_cy_reg      <= '0;
            out_cz_reg      <= '0;
            out_med_reg     <= '0;
            out_kept_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_points_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (seen_reg < CNT_W'(MAX_POINTS))
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        if (keep)
                        begin
                            sum_x_reg <= sum_x_reg + SUM_W'(x_mm);
                            sum_y_reg <= sum_y_reg + SUM_W'(y_mm);
                            sum_z_reg <= sum_z_reg + SUM_W'(z_mm);
                            kept_reg  <= kept_reg + 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    ok_reg     <= set_ok;
                    pass_reg   <= 1'b0;
                    bit_reg    <= BIT_W'(DEPTH_W - 1);
                    cand_reg   <= '0;
                    idx_reg    <= '0;
                    cnt_lt_reg <= '0;
                    dv_reg     <= 1'b0;
                    cx_reg     <= '0;
                    cy_reg     <= '0;
                    cz_reg     <= '0;
                    med_reg    <= '0;
                    div_sel_reg <= DIV_X;
                    state_reg  <= set_ok ? S_SEL : S_DONE;
                end

                S_SEL:
                begin
                    // Each pass counts stored depths below the trial value; the read
                    // data is registered and arrives in the cycle after its address.
                    dv_reg <= issuing;
                    if (issuing)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (dv_reg && (rd_data < trial_val))
                    begin
                        cnt_lt_reg <= cnt_lt_reg + 1'b1;
                    end
                    if (!issuing && !dv_reg)
                    begin
                        idx_reg    <= '0;
                        cnt_lt_reg <= '0;
                        if (cnt_lt_reg <= k_target)
                        begin
                            cand_reg <= trial_val;
                        end
                        if (bit_reg == '0)
                        begin
                            if (cnt_lt_reg <= k_target)
                            begin
                                med_a_reg <= trial_val;
                            end
                            else
                            begin
                                med_a_reg <= cand_reg;
                            end
                            bit_reg  <= BIT_W'(DEPTH_W - 1);
                            cand_reg <= '0;
                            pass_reg <= 1'b1;
                            if (pass_reg)
                            begin
                                med_reg <= 17'(med_a_reg)
                                         + 17'((cnt_lt_reg <= k_target) ? trial_val
                                                                          : cand_reg);
                                state_reg <= S_DIV_GO;
                            end
                        end
                        else
                        begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end

                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                S_DIV_WAIT:
                begin
                    if (div_st.done)
                    begin
                        case (div_sel_reg)
                            DIV_X:
                            begin
                                cx_reg      <= q_signed;
                                div_sel_reg <= DIV_Y;
                                state_reg   <= S_DIV_GO;
                            end
                            DIV_Y:
                            begin
                                cy_reg      <= q_signed;
                                div_sel_reg <= DIV_Z;
                                state_reg   <= S_DIV_GO;
                            end
                            default:
                            begin
                                cz_reg    <= q_signed;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_success_reg <= ok_reg;
                        out_cx_reg      <= cx_reg;
                        out_cy_reg      <= cy_reg;
                        out_cz_reg      <= cz_reg;
                        out_med_reg     <= med_reg;
                        out_kept_reg    <= 11'(kept_reg);
                        sum_x_reg       <= '0;
                        sum_y_reg       <= '0;
                        sum_z_reg       <= '0;
                        kept_reg        <= '0;
                        seen_reg        <= '0;
                        state_reg       <= S_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid            = out_valid_reg;
    assign success              = out_success_reg;
    assign centroid_x_mm        = out_cx_reg;
    assign centroid_y_mm        = out_cy_reg;
    assign centroid_z_mm        = out_cz_reg;
    assign median_depth_half_mm = out_med_reg;
    assign kept_points          = out_kept_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last, !in_ready, "took a beat after last")
    `ASSERT_SAME(a_fail_zero, out_valid && !success, centroid_x_mm == 16'd0 && median_depth_half_mm == 17'd0, "failed result not zero")
    `ASSERT_SAME(a_kept_bound, 1'b1, kept_reg <= seen_reg && seen_reg <= CNT_W'(MAX_POINTS), "count out of range")

endmodule

### bench/point_set_centroid_median_tb.sv
module point_set_centroid_median_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = 1024;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] z;
        logic               ok;
        logic               fin;
    } sample_t;

    typedef struct {
        logic               success;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        cz;
        logic [16:0]        median;
        logic [10:0]        kept;
    } summary_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [10:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [16:0] z_mm;
    logic sample_ok;
    logic last;
    logic out_valid;
    logic out_ready;
    logic success;
    logic signed [15:0] centroid_x_mm;
    logic signed [15:0] centroid_y_mm;
    logic [15:0] centroid_z_mm;
    logic [16:0] median_depth_half_mm;
    logic [10:0] kept_points;

    point_set_centroid_median u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm), .sample_ok(sample_ok), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .success(success), .centroid_x_mm(centroid_x_mm),
        .centroid_y_mm(centroid_y_mm), .centroid_z_mm(centroid_z_mm),
        .median_depth_half_mm(median_depth_half_mm), .kept_points(kept_points)
    );

    sample_t  sample_queue[$];
    summary_t expected_summaries[$];

    // Predictor state for the set being loaded.
    int       seen_cnt;
    int       kept_cnt;
    longint   sum_x;
    longint   sum_y;
    longint   sum_z;
    int       kept_depths[$];
    int       min_pts_cfg;

    int  errors;
    int  sets_done;
    int  sets_ok;
    int  beats_in;
    bit  no_gaps;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void predict_sample(sample_t s);
        int need;
        summary_t res;
        if (seen_cnt < MAX_PTS)
        begin
            seen_cnt++;
            if (s.ok && s.z > 0 && kept_cnt < MAX_PTS)
            begin
                kept_depths.insert(kept_depths.size(), int'(s.z));
                sum_x += s.x;
                sum_y += s.y;
                sum_z += s.z;
                kept_cnt++;
            end
        end
        if (!s.fin)
            return;
        need = (min_pts_cfg == 0) ? 1 : min_pts_cfg;
        res = '{default: '0};
        res.kept = kept_cnt[10:0];
        res.success = (kept_cnt >= 1 && kept_cnt >= need);
        if (res.success)
        begin
            kept_depths.sort();
            res.cx = 16'(sum_x / kept_cnt);
            res.cy = 16'(sum_y / kept_cnt);
            res.cz = 16'(sum_z / kept_cnt);
            if (kept_cnt % 2 == 1)
                res.median = 17'(2 * kept_depths[kept_cnt / 2]);
            else
                res.median = 17'(kept_depths[kept_cnt / 2 - 1] + kept_depths[kept_cnt / 2]);
        end
        expected_summaries.insert(expected_summaries.size(), res);
        seen_cnt = 0;
        kept_cnt = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        kept_depths.delete();
    endfunction

    // Sample driver.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_gap    <= 0;
            x_mm      <= '0;
            y_mm      <= '0;
            z_mm      <= '0;
            sample_ok <= 1'b0;
            last      <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                predict_sample('{x_mm, y_mm, z_mm, sample_ok, last});
                beats_in++;
            end
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (sample_queue.size() > 0)
            begin
                sample_t s;
                s = sample_queue.pop_front();
                in_valid  <= 1'b1;
                x_mm      <= s.x;
                y_mm      <= s.y;
                z_mm      <= s.z;
                sample_ok <= s.ok;
                last      <= s.fin;
                in_gap    <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor with random back-pressure.
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                summary_t e;
                if (expected_summaries.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_summaries.pop_front();
                    sets_done++;
                    if (e.success)
                        sets_ok++;
                    if (success !== e.success)
                    begin
                        $error("success exp %0d got %0d", e.success, success);
                        errors++;
                    end
                    if (centroid_x_mm !== e.cx)
                    begin
                        $error("centroid_x_mm exp %0d got %0d", e.cx, centroid_x_mm);
                        errors++;
                    end
                    if (centroid_y_mm !== e.cy)
                    begin
                        $error("centroid_y_mm exp %0d got %0d", e.cy, centroid_y_mm);
                        errors++;
                    end
                    if (centroid_z_mm !== e.cz)
                    begin
                        $error("centroid_z_mm exp %0d got %0d", e.cz, centroid_z_mm);
                        errors++;
                    end
                    if (median_depth_half_mm !== e.median)
                    begin
                        $error("median_depth_half_mm exp %0d got %0d",
                               e.median, median_depth_half_mm);
                        errors++;
                    end
                    if (kept_points !== e.kept)
                    begin
                        $error("kept_points exp %0d got %0d", e.kept, kept_points);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   <= pick_gap();
            end
        end
    end

    function automatic void push_sample(int x, int y, int z, bit ok, bit fin);
        sample_t s;
        s.x   = 16'(x);
        s.y   = 16'(y);
        s.z   = 17'(z);
        s.ok  = ok;
        s.fin = fin;
        sample_queue.insert(sample_queue.size(), s);
    endfunction

    // One set of random samples; ok_pct sets the percentage with sample_ok set.
    function automatic void push_set(int len, int ok_pct);
        int z;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                z = $urandom_range(1, 65535);
            else
                z = $urandom_range(0, 131071);
            push_sample($urandom, $urandom, z, $urandom_range(0, 99) < ok_pct,
                        i == len - 1);
        end
    endfunction

    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || expected_summaries.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_points(int v);
        cfg_valid <= 1'b1;
        cfg_data  <= 11'(v);
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        min_pts_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int settings[6];
        settings = '{1, 0, 2047, 1024, 3, 16};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        sets_done = 0;
        sets_ok = 0;
        beats_in = 0;
        no_gaps = 0;
        seen_cnt = 0;
        kept_cnt = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        min_pts_cfg = 16;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a set below the reset threshold, then edge values with min 1.
        push_set(5, 100);
        drain();
        write_min_points(1);
        push_sample(-32768, -32768, 65535, 1, 1);
        push_sample(32767, 32767, 1, 1, 0);
        push_sample(-32768, 32767, 0, 1, 0);
        push_sample(5, 5, -1, 1, 0);
        push_sample(5, 5, -65536, 1, 0);
        push_sample(-32768, -32768, 65535, 0, 0);
        push_sample(-3, 7, 65535, 1, 0);
        push_sample(-4, -7, 2, 1, 1);
        push_sample(1, 1, 100, 0, 1);
        push_sample(1, 1, -5, 1, 1);
        push_sample(-1, -2, 3, 1, 0);
        push_sample(0, 0, 10, 1, 0);
        push_sample(0, 0, 10, 1, 1);
        drain();

        // Random sets across several thresholds, with and without idling.
        foreach (settings[k])
        begin
            write_min_points(settings[k]);
            no_gaps = (k == 2);
            for (int n = 0; n < 7; n++)
                push_set($urandom_range(1, 40), (n == 6) ? 30 : 92);
            drain();
        end

        write_min_points($urandom_range(1, 30));
        for (int n = 0; n < 2; n++)
            push_set($urandom_range(1, 40), 90);
        drain();

        $display("Covered %0d sample beats in %0d sets, %0d of them successful.",
                 beats_in, sets_done, sets_ok);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
